// ===== src/route_slot_diff_commit_table_top_defines.svh =====
// Assertion macros used by the checker of the route slot table.
`ifndef ROUTE_SLOT_DIFF_COMMIT_TABLE_TOP_DEFINES_SVH
`define ROUTE_SLOT_DIFF_COMMIT_TABLE_TOP_DEFINES_SVH

// A clocked property that is switched off while reset is held.
`define RSDCT_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// A same-cycle implication built on the macro above.
`define RSDCT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  `RSDCT_ASSERT(lbl, ck, rn, (ante) |-> (cons), msg)

`endif

// ===== src/rsdct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsdct_pkg;

  // Default table geometry.
  localparam int SLOTS_PER_SHARD_DEF = 64;
  localparam int MAX_SHARDS_DEF      = 16;

  // The slot index field is ten bits wide, so no slot at or beyond this is ever committed.
  localparam int SLOT_SPACE = 1024;

  // The top bits of a node address, from this bit up, name the memory shard.
  localparam int SHARD_ADDR_SHIFT = 48;

  // Entries of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_DIFF   = 1'b0,
    OP_COMMIT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SAME      = 3'd1,
    ST_BAD_SLOT  = 3'd2,
    ST_BAD_LIVE  = 3'd3,
    ST_BAD_EPOCH = 3'd4,
    ST_BAD_FLAGS = 3'd5,
    ST_STALE     = 3'd6
  } status_t;

  // An item after the front has checked everything that needs no table lookup.
  typedef struct packed {
    op_t         op;
    status_t     pre_status;
    logic [3:0]  shard;
    logic [9:0]  slot;
    logic [31:0] id;
    logic [31:0] gen;
    logic        live;
    logic [63:0] node_address;
    logic [63:0] epoch;
  } item_t;

  // Entries held in the table: only slots below the ten-bit slot space can be written.
  function automatic int mem_depth(input int sps, input int ms);
    int td;
    td = sps * ms;
    return (td < SLOT_SPACE) ? td : SLOT_SPACE;
  endfunction

  function automatic int addr_width(input int sps, input int ms);
    int md;
    md = mem_depth(sps, ms);
    return (md > 1) ? $clog2(md) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/rsdct_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one diff or commit item per beat.
interface rsdct_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] shard;
  logic [9:0]  slot_index;
  logic [31:0] entry_id;
  logic [31:0] entry_generation;
  logic [7:0]  entry_flags;
  logic [63:0] node_address;
  logic [63:0] epoch;

  modport source (
    output valid, operation, shard, slot_index, entry_id, entry_generation,
           entry_flags, node_address, epoch,
    input  ready
  );
  modport sink (
    input  valid, operation, shard, slot_index, entry_id, entry_generation,
           entry_flags, node_address, epoch,
    output ready
  );
endinterface

// Result channel: one result per accepted item.
interface rsdct_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_epoch;
  logic [63:0] out_node_address;
  logic [9:0]  out_slot;
  logic [3:0]  out_shard;
  logic [31:0] out_id;
  logic [31:0] out_generation;
  logic        out_live;

  modport source (
    output valid, status, out_epoch, out_node_address, out_slot, out_shard,
           out_id, out_generation, out_live,
    input  ready
  );
  modport sink (
    input  valid, status, out_epoch, out_node_address, out_slot, out_shard,
           out_id, out_generation, out_live,
    output ready
  );
endinterface

// Configuration channel: writes the number of shards in use.
interface rsdct_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] shards_used;

  modport source (output valid, shards_used, input ready);
  modport sink (input valid, shards_used, output ready);
endinterface

`default_nettype wire

// ===== src/rsdct_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsdct_front #(
  parameter int SLOTS_PER_SHARD = rsdct_pkg::SLOTS_PER_SHARD_DEF,
  parameter int MAX_SHARDS      = rsdct_pkg::MAX_SHARDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rsdct_cfg_if.sink                 cfg_ch,
  rsdct_in_if.sink                  in_ch,
  input  wire logic                 clear_busy,
  output logic                      f_valid,
  input  wire logic                 f_ready,
  output rsdct_pkg::item_t          f_item,
  output logic [rsdct_pkg::addr_width(SLOTS_PER_SHARD, MAX_SHARDS)-1:0] f_addr,
  output logic                      f_in_mem
);

  localparam int TD = SLOTS_PER_SHARD * MAX_SHARDS;
  localparam int MD = rsdct_pkg::mem_depth(SLOTS_PER_SHARD, MAX_SHARDS);
  localparam int AW = rsdct_pkg::addr_width(SLOTS_PER_SHARD, MAX_SHARDS);
  // Global slot width: room for the largest table and for the ten-bit slot field.
  localparam int GW = (($clog2(TD) > 10) ? $clog2(TD) : 10) + 1;
  localparam int SW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;

  logic [4:0]       shards_used_r;
  logic             f_valid_r;
  rsdct_pkg::item_t item_r;
  rsdct_pkg::item_t item_nxt;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    addr_nxt;
  logic             in_mem_r;
  logic             in_mem_nxt;

  logic [GW-1:0]    base;
  logic [GW-1:0]    sidx_g;
  logic [GW-1:0]    g_sel;
  logic             live;
  logic             shard_bad;
  logic             live_bad;
  logic             epoch_bad;
  logic             commit_slot_bad;
  logic [63:0]      remote;

  // Shard count register; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shards_used_r <= 5'd1;
    end else if (cfg_ch.valid) begin
      shards_used_r <= cfg_ch.shards_used;
    end
  end

  // Checks that need only the item and the shard count.
  always_comb begin
    live      = in_ch.entry_flags[0];
    remote    = live ? in_ch.node_address : 64'd0;
    shard_bad = (in_ch.shard >= 16'(shards_used_r)) || (in_ch.shard >= 16'(MAX_SHARDS));
    epoch_bad = (in_ch.epoch == 64'd0);
    live_bad  = live && ((in_ch.node_address == 64'd0) ||
                (in_ch.node_address[63:rsdct_pkg::SHARD_ADDR_SHIFT] != in_ch.shard));
    base      = GW'(in_ch.shard[SW-1:0]) * GW'(SLOTS_PER_SHARD);
    sidx_g    = GW'(in_ch.slot_index);
    // A commit's global slot must lie within the span of its claimed shard.
    commit_slot_bad = shard_bad || (sidx_g < base) ||
                      ((sidx_g - base) >= GW'(SLOTS_PER_SHARD));

    item_nxt.shard = in_ch.shard[3:0];
    item_nxt.id    = in_ch.entry_id;
    item_nxt.gen   = in_ch.entry_generation;
    item_nxt.live  = live;
    item_nxt.epoch = in_ch.epoch;

    if (in_ch.operation == rsdct_pkg::OP_COMMIT) begin
      item_nxt.op           = rsdct_pkg::OP_COMMIT;
      item_nxt.node_address = in_ch.node_address;
      g_sel                 = sidx_g;
      if (commit_slot_bad) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_SLOT;
      end else if (epoch_bad) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_EPOCH;
      end else if (in_ch.entry_flags[7:1] != 7'd0) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_FLAGS;
      end else if (live_bad) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_LIVE;
      end else begin
        item_nxt.pre_status = rsdct_pkg::ST_OK;
      end
    end else begin
      item_nxt.op           = rsdct_pkg::OP_DIFF;
      item_nxt.node_address = remote;
      g_sel                 = base + sidx_g;
      if (epoch_bad) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_EPOCH;
      end else if (shard_bad || (11'(in_ch.slot_index) >= 11'(SLOTS_PER_SHARD))) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_SLOT;
      end else if (live_bad) begin
        item_nxt.pre_status = rsdct_pkg::ST_BAD_LIVE;
      end else begin
        item_nxt.pre_status = rsdct_pkg::ST_OK;
      end
    end

    item_nxt.slot = g_sel[9:0];
    addr_nxt      = g_sel[AW-1:0];
    // Slots beyond the stored range were never written and read as zero.
    in_mem_nxt    = (g_sel < GW'(MD));
  end

  // One register stage ahead of the queue; closed during the clearing pass.
  assign in_ch.ready = !clear_busy && (!f_valid_r || f_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      f_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r   <= item_nxt;
      addr_r   <= addr_nxt;
      in_mem_r <= in_mem_nxt;
    end
  end

  assign f_valid  = f_valid_r;
  assign f_item   = item_r;
  assign f_addr   = addr_r;
  assign f_in_mem = in_mem_r;

endmodule

`default_nettype wire

// ===== src/rsdct_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsdct_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  localparam int DEPTH = rsdct_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/rsdct_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsdct_back #(
  parameter int SLOTS_PER_SHARD = rsdct_pkg::SLOTS_PER_SHARD_DEF,
  parameter int MAX_SHARDS      = rsdct_pkg::MAX_SHARDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire rsdct_pkg::item_t     q_item,
  input  wire logic [rsdct_pkg::addr_width(SLOTS_PER_SHARD, MAX_SHARDS)-1:0] q_addr,
  input  wire logic                 q_in_mem,
  output logic                      clear_busy,
  rsdct_out_if.source               out_ch
);

  localparam int MD = rsdct_pkg::mem_depth(SLOTS_PER_SHARD, MAX_SHARDS);
  localparam int AW = rsdct_pkg::addr_width(SLOTS_PER_SHARD, MAX_SHARDS);

  typedef struct packed {
    logic [63:0] epoch;
    logic [63:0] node_address;
    logic [31:0] id;
    logic [31:0] gen;
    logic        live;
  } slot_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_r;
  rsdct_pkg::item_t  item_r;
  logic [AW-1:0]     addr_r;
  logic              in_mem_r;
  slot_t             slot_mem_r [MD];
  slot_t             rd_r;

  logic              out_valid_r;
  rsdct_pkg::status_t status_r;
  logic [63:0]       epoch_r;
  logic [63:0]       node_address_r;
  logic [9:0]        slot_r;
  logic [3:0]        shard_r;
  logic [31:0]       id_r;
  logic [31:0]       gen_r;
  logic              live_r;

  slot_t             stored;
  slot_t             new_slot;
  rsdct_pkg::status_t status_nxt;
  logic              res_valid;
  logic              same;
  logic              stale;
  logic              out_free;
  logic              commit_write;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic              mem_re;

  assign clear_busy = (state_r == S_CLEAR);
  assign q_ready    = (state_r == S_IDLE);
  assign mem_re     = q_valid && q_ready;
  assign out_free   = !out_valid_r || out_ch.ready;

  // Compare with the stored slot and settle the final status.
  always_comb begin
    stored = in_mem_r ? rd_r : '0;
    same   = (stored.id == item_r.id) && (stored.gen == item_r.gen) &&
             (stored.node_address == item_r.node_address) && (stored.live == item_r.live);
    stale  = ((stored.epoch != 64'd0) && (item_r.epoch <= stored.epoch)) ||
             ((stored.id == item_r.id) && (stored.gen > item_r.gen));
    case (item_r.pre_status)
      rsdct_pkg::ST_OK: begin
        if (item_r.op == rsdct_pkg::OP_COMMIT) begin
          status_nxt = stale ? rsdct_pkg::ST_STALE : rsdct_pkg::ST_OK;
        end else begin
          status_nxt = same ? rsdct_pkg::ST_SAME : rsdct_pkg::ST_OK;
        end
      end
      default: begin
        status_nxt = item_r.pre_status;
      end
    endcase
    res_valid = (status_nxt == rsdct_pkg::ST_OK) || (status_nxt == rsdct_pkg::ST_SAME);

    new_slot.epoch        = item_r.epoch;
    new_slot.node_address = item_r.node_address;
    new_slot.id           = item_r.id;
    new_slot.gen          = item_r.gen;
    new_slot.live         = item_r.live;

    commit_write = (state_r == S_LOOK) && out_free &&
                   (item_r.op == rsdct_pkg::OP_COMMIT) && (status_nxt == rsdct_pkg::ST_OK);
  end

  // The single write port serves the clearing pass and committed updates.
  assign mem_we    = clear_busy || commit_write;
  assign mem_waddr = clear_busy ? clr_r : addr_r;
  assign mem_wdata = clear_busy ? '0 : new_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= slot_mem_r[q_addr];
    end
  end

  // Sequencer: clear the table, then take one item, look it up and emit its result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register fills when a lookup completes and empties when its beat is taken.
      if ((state_r == S_LOOK) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MD - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            item_r   <= q_item;
            addr_r   <= q_addr;
            in_mem_r <= q_in_mem;
            state_r  <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            status_r       <= status_nxt;
            epoch_r        <= res_valid ? item_r.epoch : 64'd0;
            node_address_r <= res_valid ? item_r.node_address : 64'd0;
            slot_r         <= res_valid ? item_r.slot : 10'd0;
            shard_r        <= res_valid ? item_r.shard : 4'd0;
            id_r           <= res_valid ? item_r.id : 32'd0;
            gen_r          <= res_valid ? item_r.gen : 32'd0;
            live_r         <= res_valid && item_r.live;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.out_epoch        = epoch_r;
  assign out_ch.out_node_address = node_address_r;
  assign out_ch.out_slot         = slot_r;
  assign out_ch.out_shard        = shard_r;
  assign out_ch.out_id           = id_r;
  assign out_ch.out_generation   = gen_r;
  assign out_ch.out_live         = live_r;

endmodule

`default_nettype wire

// ===== src/route_slot_diff_commit_table_top.sv =====
// An accepted item passes the front register, the queue and the back end's lookup before its
// result fills the output register, which waits while the output is not free. The back end
// takes no new item until the last one is through: it reads the slot as it takes the item,
// then compares and writes. Reset: rst_n is synchronous, active low. The shard count returns
// to 1 and the table is swept to zero, one slot per cycle over min(SLOTS_PER_SHARD * MAX_SHARDS,
// 1024) slots, 1024 by default; no item is accepted during the sweep, configuration writes are.
`timescale 1ns / 1ps
`default_nettype none

module route_slot_diff_commit_table_top #(
  parameter int SLOTS_PER_SHARD = rsdct_pkg::SLOTS_PER_SHARD_DEF,
  parameter int MAX_SHARDS      = rsdct_pkg::MAX_SHARDS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  rsdct_cfg_if.sink    cfg_ch,
  rsdct_in_if.sink     in_ch,
  rsdct_out_if.source  out_ch
);

  localparam int AW = rsdct_pkg::addr_width(SLOTS_PER_SHARD, MAX_SHARDS);
  localparam int IW = $bits(rsdct_pkg::item_t);
  localparam int QW = IW + AW + 1;

  logic             clear_busy;
  logic             f_valid;
  logic             f_ready;
  rsdct_pkg::item_t f_item;
  logic [AW-1:0]    f_addr;
  logic             f_in_mem;
  logic             q_valid;
  logic             q_ready;
  logic [QW-1:0]    q_data;
  rsdct_pkg::item_t q_item;
  logic [AW-1:0]    q_addr;
  logic             q_in_mem;

  // Front: register the shard count, accept and classify items.
  rsdct_front #(
    .SLOTS_PER_SHARD (SLOTS_PER_SHARD),
    .MAX_SHARDS      (MAX_SHARDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .clear_busy (clear_busy),
    .f_valid    (f_valid),
    .f_ready    (f_ready),
    .f_item     (f_item),
    .f_addr     (f_addr),
    .f_in_mem   (f_in_mem)
  );

  // Short queue so that front and back stall independently.
  rsdct_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_in_mem, f_addr, f_item}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_item   = q_data[IW-1:0];
  assign q_addr   = q_data[IW+AW-1:IW];
  assign q_in_mem = q_data[QW-1];

  // Back: table lookup, compare, commit write and the output register.
  rsdct_back #(
    .SLOTS_PER_SHARD (SLOTS_PER_SHARD),
    .MAX_SHARDS      (MAX_SHARDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .q_addr     (q_addr),
    .q_in_mem   (q_in_mem),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/rsdct_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "route_slot_diff_commit_table_top_defines.svh"

module rsdct_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [63:0] out_epoch,
  input wire logic [63:0] out_node_address,
  input wire logic [31:0] out_id,
  input wire logic        out_live
);

  // A stalled result beat keeps its status.
  `RSDCT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status), "result dropped or changed while stalled")

  // Rejected items carry nothing but their status.
  `RSDCT_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (status >= rsdct_pkg::ST_BAD_SLOT), (out_epoch == 64'd0) && (out_node_address == 64'd0) && (out_id == 32'd0) && !out_live, "error result with payload")

  // Changed, written or unchanged results always carry a nonzero epoch.
  `RSDCT_ASSERT_IMP(a_ok_epoch, clk, rst_n, out_valid && (status <= rsdct_pkg::ST_SAME), out_epoch != 64'd0, "accepted result with zero epoch")

  // No status code above stale is ever produced.
  `RSDCT_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status <= rsdct_pkg::ST_STALE, "status code out of range")

  // The table sweep holds off input right after reset.
  `RSDCT_ASSERT_IMP(a_clear_hold, clk, rst_n, $past(!rst_n), !in_ready, "item taken before the table was cleared")

endmodule

bind route_slot_diff_commit_table_top rsdct_checker u_rsdct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .out_epoch        (out_ch.out_epoch),
  .out_node_address (out_ch.out_node_address),
  .out_id           (out_ch.out_id),
  .out_live         (out_ch.out_live)
);

`default_nettype wire
